// File: src/firmware_image_line_decryptor_core_assert.svh
// Assertion macros shared by the firmware image line decryptor RTL.
// Every macro samples on posedge clk and is disabled while rst_n is low.
`ifndef FIRMWARE_IMAGE_LINE_DECRYPTOR_CORE_ASSERT_SVH
`define FIRMWARE_IMAGE_LINE_DECRYPTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define FILD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FILD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fild_pkg.sv
// Package for the firmware image line decryptor: word types, state and
// configuration structs, and the constants of the line format. No dependencies.
`timescale 1ns / 1ps

package fild_pkg;

  localparam int LINES_PER_BLOCK = 4;
  localparam int LINE_IDX_W = (LINES_PER_BLOCK > 1) ? $clog2(LINES_PER_BLOCK) : 1;

  localparam int LINE_DATA_BYTES = 16;
  localparam int LINE_BYTES      = LINE_DATA_BYTES + 2;

  localparam logic [4:0] POS_ADDR_LO  = 5'd0;
  localparam logic [4:0] POS_ADDR_HI  = 5'd1;
  localparam logic [4:0] POS_FIRST_DATA = 5'd2;
  localparam logic [3:0] IDX_LAST     = 4'(LINE_DATA_BYTES - 1);
  localparam logic [7:0] INDEX_OFFSET = 8'd117;
  localparam logic [LINE_IDX_W-1:0] LINE_LAST = LINE_IDX_W'(LINES_PER_BLOCK - 1);
  localparam logic [LINE_IDX_W-1:0] LINE_STEP = LINE_IDX_W'(1);

  // Input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_INITIAL_KEY   = 2'd0;
  localparam logic [1:0] CFG_PROTECT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TOP_BLOCK     = 2'd2;

  localparam logic [7:0]  RST_INITIAL_KEY   = 8'd0;
  localparam logic [15:0] RST_PROTECT_LIMIT = 16'd2048;
  localparam logic [15:0] RST_TOP_BLOCK     = 16'd65472;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       encrypted;
  } in_item_t;

  typedef struct packed {
    logic [15:0] flash_address;
    logic [7:0]  plain_byte;
    logic        write_enable;
    logic        block_end;
    logic        update_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  initial_key;
    logic [15:0] protect_limit;
    logic [15:0] top_block_address;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0]            running_key;
    logic [7:0]            line_checksum;
    logic [4:0]            byte_position;
    logic [LINE_IDX_W-1:0] line_index;
    logic [7:0]            address_low_byte;
    logic [7:0]            address_high_byte;
    logic [15:0]           block_base;
    logic                  update_active;
    logic                  image_encrypted;
  } dec_state_t;

endpackage

// File: src/fild_step.sv
// Per-word decode step: next decoder state and the optional result word.
// Pure combinational logic; depends on fild_pkg.
`timescale 1ns / 1ps

module fild_step (
  input  fild_pkg::in_item_t   item,
  input  fild_pkg::dec_state_t st,
  input  fild_pkg::cfg_regs_t  cfg,
  output fild_pkg::dec_state_t st_nxt,
  output logic                 has_result,
  output fild_pkg::out_item_t  result
);

  logic [3:0]  idx;
  logic [4:0]  pos_off;
  logic [7:0]  mask;
  logic [7:0]  plain;
  logic [7:0]  cks_x;
  logic        last_in_line;
  logic        last_line;
  logic        is_top;
  logic [15:0] line_offset;

  assign pos_off      = st.byte_position - fild_pkg::POS_FIRST_DATA;
  assign idx          = pos_off[3:0];
  assign last_in_line = (idx == fild_pkg::IDX_LAST);
  assign last_line    = (st.line_index == fild_pkg::LINE_LAST);
  assign is_top       = (st.block_base == cfg.top_block_address);
  assign mask = {st.running_key[6:0], 1'b0} ^ ({4'b0, idx} + fild_pkg::INDEX_OFFSET)
              ^ st.address_low_byte ^ st.address_high_byte;
  assign plain = st.image_encrypted ? (item.data ^ mask) : item.data;
  assign cks_x = st.line_checksum ^ plain;
  assign line_offset = {{(12 - fild_pkg::LINE_IDX_W){1'b0}}, st.line_index, 4'b0};

  always_comb begin
    st_nxt     = st;
    has_result = 1'b0;
    result.flash_address = st.block_base + line_offset + {12'b0, idx};
    result.plain_byte    = plain;
    result.write_enable  = (st.block_base >= cfg.protect_limit);
    result.block_end     = last_in_line && last_line;
    result.update_done   = last_in_line && last_line && is_top;

    if (item.cmd == fild_pkg::CMD_START) begin
      st_nxt.running_key     = cfg.initial_key;
      st_nxt.line_checksum   = 8'd0;
      st_nxt.byte_position   = fild_pkg::POS_ADDR_LO;
      st_nxt.line_index      = '0;
      st_nxt.image_encrypted = item.encrypted;
      st_nxt.update_active   = 1'b1;
    end else if (st.update_active) begin
      if (st.byte_position == fild_pkg::POS_ADDR_LO) begin
        st_nxt.address_low_byte = item.data;
        st_nxt.byte_position    = fild_pkg::POS_ADDR_HI;
      end else if (st.byte_position == fild_pkg::POS_ADDR_HI) begin
        st_nxt.address_high_byte = item.data;
        if (st.line_index == '0) begin
          st_nxt.block_base = {item.data, st.address_low_byte};
        end
        st_nxt.byte_position = fild_pkg::POS_FIRST_DATA;
      end else begin
        has_result = 1'b1;
        // Key and checksum only run on encrypted images
        if (st.image_encrypted) begin
          st_nxt.line_checksum = cks_x;
          if (last_in_line) begin
            st_nxt.running_key   = st.running_key ^ cks_x;
            st_nxt.line_checksum = 8'd0;
          end
        end
        if (last_in_line) begin
          st_nxt.byte_position = fild_pkg::POS_ADDR_LO;
          if (last_line) begin
            st_nxt.line_index = '0;
            if (is_top) begin
              st_nxt.update_active = 1'b0;
            end
          end else begin
            st_nxt.line_index = st.line_index + fild_pkg::LINE_STEP;
          end
        end else begin
          st_nxt.byte_position = st.byte_position + 5'd1;
        end
      end
    end
  end

endmodule

// File: src/fild_skid.sv
// Result register with one skid entry, so the input side takes one more word
// while a result waits downstream. Depends on fild_pkg and the assert header.
`timescale 1ns / 1ps
`include "firmware_image_line_decryptor_core_assert.svh"

module fild_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fild_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output fild_pkg::out_item_t out_item
);

  logic                main_valid_r, main_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  fild_pkg::out_item_t main_r, main_nxt;
  fild_pkg::out_item_t skid_r, skid_nxt;
  logic                pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_item  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // Drain the skid entry first; no push arrives while full
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_item;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_item;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  `FILD_ASSERT_NOW(a_skid_behind_main, skid_valid_r, main_valid_r, "skid word without main word")
  `FILD_ASSERT_NEXT(a_skid_holds, skid_valid_r && out_stall, skid_valid_r && $stable(skid_r),
                    "skid word lost while stalled")
  `FILD_ASSERT_NEXT(a_push_lands, push && !main_valid_r, main_valid_r && (main_r == $past(push_item)),
                    "pushed word not in result register")

endmodule

// File: src/firmware_image_line_decryptor_core.sv
// Top level of the firmware image line decryptor: configuration registers,
// decoder state, decode step and result buffer. Depends on fild_pkg,
// fild_step, fild_skid and the assert header.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+--------------------------
//   input   | in_valid, in_stall, in_item    | valid && !stall
//   result  | out_valid, out_stall, out_item | valid && !stall
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// One input word per cycle when not stalled; data byte results are registered.
// The decoder state updates in the accept cycle through one XOR/add step.
// in_stall rises only when both the result register and its skid entry hold
// words; it is a registered flag. Reset (rst_n low, synchronous) clears the
// decoder state and loads the configuration defaults. cfg_ready is always high.
`timescale 1ns / 1ps
`include "firmware_image_line_decryptor_core_assert.svh"

module firmware_image_line_decryptor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fild_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fild_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  fild_pkg::cfg_regs_t  cfg_r, cfg_nxt;
  fild_pkg::dec_state_t st_r, st_nxt, st_step;
  fild_pkg::out_item_t  result;
  logic                 has_result;
  logic                 accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  fild_step u_step (
    .item       (in_item),
    .st         (st_r),
    .cfg        (cfg_r),
    .st_nxt     (st_step),
    .has_result (has_result),
    .result     (result)
  );

  fild_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && has_result),
    .push_item (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fild_pkg::CFG_INITIAL_KEY:   cfg_nxt.initial_key       = cfg_data[7:0];
        fild_pkg::CFG_PROTECT_LIMIT: cfg_nxt.protect_limit     = cfg_data;
        fild_pkg::CFG_TOP_BLOCK:     cfg_nxt.top_block_address = cfg_data;
        default: ;
      endcase
    end
  end

  assign st_nxt = accept ? st_step : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_key       <= fild_pkg::RST_INITIAL_KEY;
      cfg_r.protect_limit     <= fild_pkg::RST_PROTECT_LIMIT;
      cfg_r.top_block_address <= fild_pkg::RST_TOP_BLOCK;
      st_r                    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      st_r  <= st_nxt;
    end
  end

  `FILD_ASSERT_NOW(a_pos_in_line, 1'b1, st_r.byte_position <= 5'(fild_pkg::LINE_BYTES - 1),
                   "byte position past end of line")
  `FILD_ASSERT_NEXT(a_start_arms, accept && (in_item.cmd == fild_pkg::CMD_START),
                    st_r.update_active && (st_r.byte_position == fild_pkg::POS_ADDR_LO),
                    "start did not arm the update")
  `FILD_ASSERT_NOW(a_done_on_block_end, out_valid && out_item.update_done, out_item.block_end,
                   "update done outside a block end")

endmodule
